/* design/bpa_pkg.sv */
// ----------------------------------------------------------------------------
// Buddy page allocator package
// Sizes, codes, page word layout and sequencer states shared by the design.
// ----------------------------------------------------------------------------
`default_nettype none

package bpa_pkg;

  localparam int NUM_PAGES  = 1024;
  localparam int NUM_ORDERS = 11;
  localparam int PAGE_BYTES = 4096;   // power of two

  localparam int PG_W      = $clog2(NUM_PAGES);
  localparam int LINK_W    = $clog2(NUM_PAGES + 1);
  localparam int ORD_W     = $clog2(NUM_ORDERS + 1);
  localparam int HIDX_W    = $clog2(NUM_ORDERS);
  localparam int PB_LOG    = $clog2(PAGE_BYTES);
  localparam int TOP_ORDER = NUM_ORDERS - 1;
  localparam int TOP_SIZE  = 1 << TOP_ORDER;
  localparam int BUD_W     = ((PG_W > NUM_ORDERS) ? PG_W : NUM_ORDERS) + 1;

  localparam int ADDR_W    = 32;
  localparam int SIZE_W    = 23;
  localparam int OUT_ORD_W = 4;
  localparam int ST_W      = 2;
  localparam int PAGES_W   = SIZE_W - PB_LOG + 1;
  localparam int REQ_W     = $clog2(PAGES_W + 1);
  localparam int PADDR_W   = 3;

  localparam logic [LINK_W-1:0] NIL      = LINK_W'(NUM_PAGES);
  localparam logic [ORD_W-1:0]  NO_ORDER = ORD_W'(NUM_ORDERS);
  localparam logic [ORD_W-1:0]  TOP      = ORD_W'(TOP_ORDER);
  localparam logic [LINK_W-1:0] LAST_TOP = (NUM_PAGES >= TOP_SIZE) ?
      LINK_W'((NUM_PAGES / TOP_SIZE - 1) * TOP_SIZE) : NIL;

  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_BAD_SIZE = 2'd1;
  localparam logic [ST_W-1:0] ST_NO_BLOCK = 2'd2;
  localparam logic [ST_W-1:0] ST_IGNORED  = 2'd3;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic REG_BASE = 1'b0;
  localparam logic REG_MAX  = 1'b1;

  typedef struct packed {
    logic [ORD_W-1:0]  ord;
    logic              fh;
    logic [LINK_W-1:0] nx;
    logic [LINK_W-1:0] pv;
  } page_word_t;

  typedef enum logic [17:0] {
    S_CLEAR    = 18'h00001,
    S_IDLE     = 18'h00002,
    S_DECODE   = 18'h00004,
    S_A_SEARCH = 18'h00008,
    S_A_SPLIT  = 18'h00010,
    S_F_CHK    = 18'h00020,
    S_F_MERGE  = 18'h00040,
    S_F_BUD    = 18'h00080,
    S_F_JOIN   = 18'h00100,
    S_F_PUSH   = 18'h00200,
    S_F_DONE   = 18'h00400,
    S_U_START  = 18'h00800,
    S_U_PWR    = 18'h01000,
    S_U_NCHK   = 18'h02000,
    S_U_NWR    = 18'h04000,
    S_U_SELF   = 18'h08000,
    S_P_START  = 18'h10000,
    S_P_HWR    = 18'h20000
  } state_t;

endpackage

`default_nettype wire

/* design/buddy_page_allocator.sv */
// ----------------------------------------------------------------------------
// Buddy page allocator
// Allocates and frees power-of-two blocks of pages with merge on free.
// ----------------------------------------------------------------------------
`default_nettype none

// After reset the block runs a clearing pass over all NUM_PAGES (1024) words of
// the page memory with busy high; configuration writes are taken meanwhile.
// A command transfers when start is high and busy is low. Each command gives
// exactly one result, shown for one cycle with done high; the receiver cannot
// stall it. The page words sit in one single-port-read, single-port-write
// memory with a registered read, and the sequencer walks it. A command is
// rejected at decode, or a free at the check of its page word; an allocate
// searches the orders and then splits level by level, and a free merges level
// by level, at most up to the top order. The worst case is a free that merges
// all the way to the top order, set by the read-modify-write steps on the page
// memory for each level.
module buddy_page_allocator
  import bpa_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic                 op,
  input  wire logic [SIZE_W-1:0]    alloc_size,
  input  wire logic [ADDR_W-1:0]    free_address,
  output logic                      done,
  output logic [ADDR_W-1:0]         block_address,
  output logic [OUT_ORD_W-1:0]      block_order,
  output logic [ST_W-1:0]           status,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [PADDR_W-1:0]   paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  // Configuration registers
  logic [ADDR_W-1:0] base_address;
  logic [SIZE_W-1:0] max_alloc_bytes;

  // Sequencer state
  state_t            state, ret;
  logic              op_r;
  logic [SIZE_W-1:0] size_r;
  logic [ADDR_W-1:0] faddr_r;
  logic [PG_W-1:0]   pg, upg, ppg, budr, clr_idx;
  logic [ORD_W-1:0]  cur, req, uord, pord;
  logic [LINK_W-1:0] un, up, ph;
  logic [LINK_W-1:0] heads [NUM_ORDERS];

  // Page memory
  page_word_t        mem [NUM_PAGES];
  page_word_t        rdata, wdata;
  logic              we, re;
  logic [PG_W-1:0]   waddr, raddr;

  // Decode helpers
  logic [PAGES_W-1:0]        pages;
  logic [REQ_W-1:0]          req_calc;
  logic [ADDR_W-1:0]         off;
  logic [ADDR_W-PB_LOG-1:0]  pg_full;
  logic                      bad_size, bad_free;
  logic [BUD_W-1:0]          bud_w;
  logic                      bud_ok;
  logic [LINK_W-1:0]         head_cur, head_u, head_p;
  logic [PG_W-1:0]           pg_hi, pg_lo;

  function automatic page_word_t init_word(input logic [PG_W-1:0] idx);
    int         ii;
    page_word_t w;
    ii   = int'(idx);
    w.ord = NO_ORDER;
    w.fh  = 1'b0;
    w.nx  = NIL;
    w.pv  = NIL;
    if ((ii % TOP_SIZE) == 0 && ii + TOP_SIZE <= NUM_PAGES) begin
      w.ord = TOP;
      w.fh  = 1'b1;
      w.nx  = (ii >= TOP_SIZE) ? LINK_W'(ii - TOP_SIZE) : NIL;
      w.pv  = (ii + 2 * TOP_SIZE <= NUM_PAGES) ? LINK_W'(ii + TOP_SIZE) : NIL;
    end
    return w;
  endfunction

  function automatic page_word_t plain_word(input logic [ORD_W-1:0] o);
    page_word_t w;
    w.ord = o;
    w.fh  = 1'b0;
    w.nx  = NIL;
    w.pv  = NIL;
    return w;
  endfunction

  assign busy   = (state != S_IDLE);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX) ? {{(32-SIZE_W){1'b0}}, max_alloc_bytes}
                                        : base_address;

  // Round the size up to pages, then to an order
  assign pages    = PAGES_W'(size_r >> PB_LOG) + PAGES_W'(|size_r[PB_LOG-1:0]);
  assign bad_size = (size_r == '0) || (size_r > max_alloc_bytes);

  always_comb begin
    req_calc = REQ_W'(PAGES_W);
    for (int j = PAGES_W; j >= 0; j--) begin
      if (((PAGES_W+1)'(1) << j) >= {1'b0, pages}) req_calc = REQ_W'(j);
    end
  end

  assign off      = faddr_r - base_address;
  assign pg_full  = off[ADDR_W-1:PB_LOG];
  assign bad_free = (faddr_r == '0) || (faddr_r < base_address) ||
                    (pg_full >= (ADDR_W-PB_LOG)'(NUM_PAGES));

  assign bud_w  = BUD_W'(pg) ^ (BUD_W'(1) << cur);
  assign bud_ok = (cur < TOP) && (bud_w < BUD_W'(NUM_PAGES));
  assign pg_hi  = (pg > budr) ? pg : budr;
  assign pg_lo  = (pg > budr) ? budr : pg;

  assign head_cur = heads[cur[HIDX_W-1:0]];
  assign head_u   = heads[uord[HIDX_W-1:0]];
  assign head_p   = heads[pord[HIDX_W-1:0]];

  // Memory port control
  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = pg;
    raddr = pg;
    wdata = rdata;
    unique case (state)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_idx;
        wdata = init_word(clr_idx);
      end
      S_DECODE: begin
        re    = (op_r == OP_FREE) && !bad_free;
        raddr = pg_full[PG_W-1:0];
      end
      S_A_SEARCH: begin
        re    = (head_cur != NIL);
        raddr = head_cur[PG_W-1:0];
      end
      S_A_SPLIT: begin
        we    = (cur <= req);
        wdata = plain_word(req);
      end
      S_F_MERGE: begin
        re    = bud_ok;
        raddr = bud_w[PG_W-1:0];
      end
      S_F_JOIN: begin
        we    = 1'b1;
        waddr = pg_hi;
        wdata = plain_word(NO_ORDER);
      end
      S_U_START: begin
        re    = (head_u != LINK_W'(upg)) && (rdata.pv != NIL);
        raddr = rdata.pv[PG_W-1:0];
      end
      S_U_PWR: begin
        we       = 1'b1;
        waddr    = up[PG_W-1:0];
        wdata.nx = un;
      end
      S_U_NCHK: begin
        re    = (un != NIL);
        raddr = un[PG_W-1:0];
      end
      S_U_NWR: begin
        we       = 1'b1;
        waddr    = un[PG_W-1:0];
        wdata.pv = (head_u == un) ? NIL : up;
      end
      S_U_SELF: begin
        we    = 1'b1;
        waddr = upg;
        wdata = plain_word(uord);
      end
      S_P_START: begin
        we       = 1'b1;
        waddr    = ppg;
        wdata.ord = pord;
        wdata.fh  = 1'b1;
        wdata.nx  = head_p;
        wdata.pv  = NIL;
        re       = (head_p != NIL);
        raddr    = head_p[PG_W-1:0];
      end
      S_P_HWR: begin
        we       = 1'b1;
        waddr    = ph[PG_W-1:0];
        wdata.pv = LINK_W'(ppg);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address    <= '0;
      max_alloc_bytes <= SIZE_W'(4194304);
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_BASE) base_address <= pwdata;
      else max_alloc_bytes <= pwdata[SIZE_W-1:0];
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      ret     <= S_IDLE;
      clr_idx <= '0;
      done    <= 1'b0;
      for (int k = 0; k < NUM_ORDERS; k++) heads[k] <= (k == TOP_ORDER) ? LAST_TOP : NIL;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == PG_W'(NUM_PAGES - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            op_r    <= op;
            size_r  <= alloc_size;
            faddr_r <= free_address;
            state   <= S_DECODE;
          end
        end
        S_DECODE: begin
          block_address <= '0;
          block_order   <= '0;
          if (op_r == OP_ALLOC) begin
            if (bad_size) begin
              status <= ST_BAD_SIZE;
              done   <= 1'b1;
              state  <= S_IDLE;
            end else if (int'(req_calc) > TOP_ORDER) begin
              status <= ST_NO_BLOCK;
              done   <= 1'b1;
              state  <= S_IDLE;
            end else begin
              req   <= ORD_W'(req_calc);
              cur   <= ORD_W'(req_calc);
              state <= S_A_SEARCH;
            end
          end else if (bad_free) begin
            status <= ST_IGNORED;
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            pg    <= pg_full[PG_W-1:0];
            state <= S_F_CHK;
          end
        end
        S_A_SEARCH: begin
          // Take the first nonempty list at or above the wanted order
          if (head_cur != NIL) begin
            pg    <= head_cur[PG_W-1:0];
            upg   <= head_cur[PG_W-1:0];
            uord  <= cur;
            ret   <= S_A_SPLIT;
            state <= S_U_START;
          end else if (cur == TOP) begin
            status <= ST_NO_BLOCK;
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            cur <= cur + 1'b1;
          end
        end
        S_A_SPLIT: begin
          // Push each upper half on the next lower list
          if (cur > req) begin
            cur   <= cur - 1'b1;
            pord  <= cur - 1'b1;
            ppg   <= pg | (PG_W'(1) << (cur - 1'b1));
            ret   <= S_A_SPLIT;
            state <= S_P_START;
          end else begin
            block_address <= base_address + (ADDR_W'(pg) << PB_LOG);
            block_order   <= OUT_ORD_W'(req);
            status        <= ST_OK;
            done          <= 1'b1;
            state         <= S_IDLE;
          end
        end
        S_F_CHK: begin
          if (rdata.fh || rdata.ord >= NO_ORDER) begin
            status <= ST_IGNORED;
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            cur   <= rdata.ord;
            state <= S_F_MERGE;
          end
        end
        S_F_MERGE: begin
          if (bud_ok) begin
            budr  <= bud_w[PG_W-1:0];
            state <= S_F_BUD;
          end else begin
            state <= S_F_PUSH;
          end
        end
        S_F_BUD: begin
          if (!rdata.fh || rdata.ord != cur) begin
            state <= S_F_PUSH;
          end else begin
            upg   <= budr;
            uord  <= cur;
            ret   <= S_F_JOIN;
            state <= S_U_START;
          end
        end
        S_F_JOIN: begin
          // Upper half stops heading a block; carry on with the lower one
          pg    <= pg_lo;
          cur   <= cur + 1'b1;
          state <= S_F_MERGE;
        end
        S_F_PUSH: begin
          ppg   <= pg;
          pord  <= cur;
          ret   <= S_F_DONE;
          state <= S_P_START;
        end
        S_F_DONE: begin
          block_address <= '0;
          block_order   <= OUT_ORD_W'(cur);
          status        <= ST_OK;
          done          <= 1'b1;
          state         <= S_IDLE;
        end
        S_U_START: begin
          // Unlink upg from list uord; its word is in rdata
          un <= rdata.nx;
          up <= rdata.pv;
          if (head_u == LINK_W'(upg)) begin
            heads[uord[HIDX_W-1:0]] <= rdata.nx;
            state <= S_U_NCHK;
          end else if (rdata.pv != NIL) begin
            state <= S_U_PWR;
          end else begin
            state <= S_U_NCHK;
          end
        end
        S_U_PWR:  state <= S_U_NCHK;
        S_U_NCHK: state <= (un != NIL) ? S_U_NWR : S_U_SELF;
        S_U_NWR:  state <= S_U_SELF;
        S_U_SELF: state <= ret;
        S_P_START: begin
          heads[pord[HIDX_W-1:0]] <= LINK_W'(ppg);
          ph    <= head_p;
          state <= (head_p != NIL) ? S_P_HWR : ret;
        end
        S_P_HWR: state <= ret;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  a_done_single : assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe held for two cycles");

  a_reject_zero : assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (block_address == '0 && block_order == '0))
    else $error("rejected command carries address or order");

  a_idle_no_wr : assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !we) else $error("page memory written while idle");

  a_free_no_addr : assert property (@(posedge clk) disable iff (rst)
    (done && $past(state) == S_F_DONE) |-> (block_address == '0))
    else $error("free returned an address");

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Buddy page allocator testbench
// Drives allocate and free commands through the start/busy handshake and sets
// the registers over APB. A page-level model of the free lists, links and
// orders predicts every result, and each done strobe is checked against it.
// ----------------------------------------------------------------------------
module tb_top;
  import bpa_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int N_RANDOM    = 500;
  localparam int N_PHASES    = 5;

  typedef struct {
    logic [ADDR_W-1:0]    addr;
    logic [OUT_ORD_W-1:0] ord;
    logic [ST_W-1:0]      st;
  } alloc_result_t;

  typedef enum {ROW_CMD, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic              op;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] addr;
    bit                known;
    alloc_result_t     res;
    logic              reg_idx;
    logic [31:0]       reg_val;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 op = OP_ALLOC;
  logic [SIZE_W-1:0]    alloc_size = '0;
  logic [ADDR_W-1:0]    free_address = '0;
  logic                 done;
  logic [ADDR_W-1:0]    block_address;
  logic [OUT_ORD_W-1:0] block_order;
  logic [ST_W-1:0]      status;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [PADDR_W-1:0]   paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;

  buddy_page_allocator u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .alloc_size(alloc_size), .free_address(free_address), .done(done),
    .block_address(block_address), .block_order(block_order), .status(status),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the allocator: registers, free lists and per-page words
  logic [31:0]   sh_base;
  logic [22:0]   sh_max;
  int            sh_head [NUM_ORDERS];
  int            sh_ord  [NUM_PAGES];
  bit            sh_fh   [NUM_PAGES];
  int            sh_nx   [NUM_PAGES];
  int            sh_pv   [NUM_PAGES];

  alloc_result_t pending_results[$];
  int            live_pages[$];
  int            errors = 0;
  int            cycles = 0;
  bit            no_gaps = 0;

  function automatic void shadow_reset();
    sh_base = '0;
    sh_max  = 23'd4194304;
    for (int i = 0; i < NUM_ORDERS; i++) sh_head[i] = NUM_PAGES;
    for (int i = 0; i < NUM_PAGES; i++) begin
      sh_ord[i] = NUM_ORDERS;
      sh_fh[i]  = 0;
      sh_nx[i]  = NUM_PAGES;
      sh_pv[i]  = NUM_PAGES;
    end
    for (int i = 0; i + TOP_SIZE <= NUM_PAGES; i += TOP_SIZE) list_push(i, TOP_ORDER);
  endfunction

  function automatic void list_push(int pg, int ord);
    int h;
    h = sh_head[ord];
    sh_pv[pg] = NUM_PAGES;
    sh_nx[pg] = h;
    if (h != NUM_PAGES) sh_pv[h] = pg;
    sh_head[ord] = pg;
    sh_ord[pg] = ord;
    sh_fh[pg] = 1;
  endfunction

  function automatic void list_unlink(int pg, int ord);
    int n;
    int p;
    n = sh_nx[pg];
    p = sh_pv[pg];
    if (sh_head[ord] == pg) sh_head[ord] = n;
    else if (p != NUM_PAGES) sh_nx[p] = n;
    if (n != NUM_PAGES) sh_pv[n] = (sh_head[ord] == n) ? NUM_PAGES : p;
    sh_nx[pg] = NUM_PAGES;
    sh_pv[pg] = NUM_PAGES;
    sh_fh[pg] = 0;
  endfunction

  // Work out the result of one command and advance the shadow state.
  // Live pages are tracked here so that frees can target real blocks.
  function automatic alloc_result_t allocate_or_free(logic cmd, logic [22:0] size,
                                                     logic [31:0] addr);
    alloc_result_t r;
    int pages;
    int ord;
    int pg;
    int bud;
    int lo;
    r = '{addr: '0, ord: '0, st: ST_OK};
    if (cmd == OP_ALLOC) begin
      if (size == 0 || size > sh_max) begin
        r.st = ST_BAD_SIZE;
        return r;
      end
      pages = (size + PAGE_BYTES - 1) / PAGE_BYTES;
      ord = 0;
      while (ord < 31 && (1 << ord) < pages) ord++;
      for (int i = ord; i < NUM_ORDERS; i++) begin
        if (sh_head[i] == NUM_PAGES) continue;
        pg = sh_head[i];
        list_unlink(pg, i);
        for (int k = i - 1; k >= ord; k--) list_push(pg + (1 << k), k);
        sh_ord[pg] = ord;
        r.addr = sh_base + 32'(pg * PAGE_BYTES);
        r.ord  = ord[OUT_ORD_W-1:0];
        live_pages.push_back(pg);
        return r;
      end
      r.st = ST_NO_BLOCK;
      return r;
    end
    if (addr == 0 || addr < sh_base) begin
      r.st = ST_IGNORED;
      return r;
    end
    pg = int'((addr - sh_base) / PAGE_BYTES);
    if ((addr - sh_base) / PAGE_BYTES >= NUM_PAGES || sh_fh[pg] || sh_ord[pg] >= NUM_ORDERS) begin
      r.st = ST_IGNORED;
      return r;
    end
    foreach (live_pages[i]) if (live_pages[i] == pg) begin
      live_pages.delete(i);
      break;
    end
    ord = sh_ord[pg];
    while (ord < TOP_ORDER) begin
      bud = pg ^ (1 << ord);
      if (bud >= NUM_PAGES || !sh_fh[bud] || sh_ord[bud] != ord) break;
      list_unlink(bud, ord);
      lo = (pg < bud) ? pg : bud;
      sh_ord[(pg < bud) ? bud : pg] = NUM_ORDERS;
      ord++;
      sh_ord[lo] = ord;
      pg = lo;
    end
    list_push(pg, ord);
    r.ord = ord[OUT_ORD_W-1:0];
    return r;
  endfunction

  function automatic int gap_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (no_gaps || pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 70);
  endfunction

  // Hold the command until it transfers, then log what it must return.
  // start stays high afterwards; the caller lowers it for a gap.
  task automatic issue(logic cmd, logic [22:0] size, logic [31:0] addr, bit known,
                       alloc_result_t typed);
    alloc_result_t r;
    @(negedge clk);
    start = 1'b1;
    op = cmd;
    alloc_size = size;
    free_address = addr;
    do @(posedge clk); while (busy);
    r = allocate_or_free(cmd, size, addr);
    pending_results.push_back(known ? typed : r);
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Drain the block before touching a register, then write and read back
  task automatic reg_write(logic idx, logic [31:0] val);
    @(negedge clk);
    start = 1'b0;
    do @(posedge clk); while (pending_results.size() != 0 || busy);
    repeat (4) @(posedge clk);
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = PADDR_W'({idx, 2'b00});
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b0; penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    if (idx == REG_BASE) sh_base = val;
    else sh_max = val[22:0];
    if (prdata != ((idx == REG_BASE) ? sh_base : {9'b0, sh_max})) begin
      $display("%0t: register %0d readback expected %h actual %h", $time, idx,
               (idx == REG_BASE) ? sh_base : {9'b0, sh_max}, prdata);
      errors++;
    end
    @(negedge clk);
    psel = 1'b0; penable = 1'b0;
  endtask

  // Result checker: every done strobe must match the oldest expectation
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result addr %h ord %0d status %0d", $time,
                 block_address, block_order, status);
        errors++;
      end else begin
        if (block_address !== pending_results[0].addr) begin
          $display("%0t: block_address expected %h actual %h", $time,
                   pending_results[0].addr, block_address);
          errors++;
        end
        if (block_order !== pending_results[0].ord) begin
          $display("%0t: block_order expected %0d actual %0d", $time,
                   pending_results[0].ord, block_order);
          errors++;
        end
        if (status !== pending_results[0].st) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   pending_results[0].st, status);
          errors++;
        end
        void'(pending_results.pop_front());
      end
    end
  end

  // Watchdog: allows for the clearing pass and the slowest legal run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic stim_row_t cmd_row(logic cmd, logic [22:0] size, logic [31:0] addr);
    stim_row_t s;
    s = '{kind: ROW_CMD, op: cmd, size: size, addr: addr, known: 0,
          res: '{addr: '0, ord: '0, st: ST_OK}, reg_idx: REG_BASE, reg_val: '0};
    return s;
  endfunction

  function automatic stim_row_t chk_row(logic cmd, logic [22:0] size, logic [31:0] addr,
                                        logic [31:0] ea, logic [3:0] eo, logic [1:0] es);
    stim_row_t s;
    s = cmd_row(cmd, size, addr);
    s.known = 1;
    s.res = '{addr: ea, ord: eo, st: es};
    return s;
  endfunction

  function automatic stim_row_t cfg_row(logic idx, logic [31:0] val);
    stim_row_t s;
    s = cmd_row(OP_ALLOC, '0, '0);
    s.kind = ROW_CFG;
    s.reg_idx = idx;
    s.reg_val = val;
    return s;
  endfunction

  initial begin
    stim_row_t     tbl[$];
    alloc_result_t none;
    int            pick;
    logic          cmd;
    logic [22:0]   size;
    logic [31:0]   addr;

    none = '{addr: '0, ord: '0, st: ST_OK};
    shadow_reset();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part: reset state, size and address extremes, every status
    tbl.push_back(chk_row(OP_ALLOC, 23'd0, 32'h1234_5678, 0, 0, ST_BAD_SIZE));
    tbl.push_back(chk_row(OP_ALLOC, 23'd4194305, 0, 0, 0, ST_BAD_SIZE));
    tbl.push_back(chk_row(OP_ALLOC, 23'h7FFFFF, 32'hFFFF_FFFF, 0, 0, ST_BAD_SIZE));
    tbl.push_back(chk_row(OP_FREE, 23'h7FFFFF, 32'h0, 0, 0, ST_IGNORED));
    tbl.push_back(chk_row(OP_FREE, 23'd5, 32'hFFFF_FFFF, 0, 0, ST_IGNORED));
    tbl.push_back(chk_row(OP_FREE, 23'd0, 32'h0000_1000, 0, 0, ST_IGNORED));
    tbl.push_back(chk_row(OP_ALLOC, 23'd4194304, 0, 32'h0, 4'd10, ST_OK));
    tbl.push_back(chk_row(OP_ALLOC, 23'd1, 0, 0, 0, ST_NO_BLOCK));
    // Move page zero off address zero so that it can be released
    tbl.push_back(cfg_row(REG_BASE, 32'h4000_0000));
    tbl.push_back(chk_row(OP_FREE, 0, 32'h4000_0000, 0, 4'd10, ST_OK));
    tbl.push_back(chk_row(OP_FREE, 0, 32'h4000_0000, 0, 0, ST_IGNORED));
    tbl.push_back(cmd_row(OP_ALLOC, 23'd4097, 0));
    tbl.push_back(cmd_row(OP_ALLOC, 23'd1, 0));
    tbl.push_back(cmd_row(OP_ALLOC, 23'd4096, 0));
    tbl.push_back(chk_row(OP_FREE, 0, 32'h3FFF_FFFF, 0, 0, ST_IGNORED));
    tbl.push_back(chk_row(OP_FREE, 0, 32'h4040_0000, 0, 0, ST_IGNORED));
    tbl.push_back(cmd_row(OP_FREE, 0, 32'h4000_0800));
    tbl.push_back(cmd_row(OP_FREE, 0, 32'h4000_3000));
    tbl.push_back(cfg_row(REG_MAX, 32'd1));
    tbl.push_back(chk_row(OP_ALLOC, 23'd2, 0, 0, 0, ST_BAD_SIZE));
    tbl.push_back(cmd_row(OP_ALLOC, 23'd1, 0));
    // A limit above the top block size exposes the order beyond top case
    tbl.push_back(cfg_row(REG_MAX, 32'h007F_FFFF));
    tbl.push_back(chk_row(OP_ALLOC, 23'd4194305, 0, 0, 0, ST_NO_BLOCK));
    tbl.push_back(cfg_row(REG_BASE, 32'hFFFF_F000));
    tbl.push_back(cmd_row(OP_ALLOC, 23'd8192, 0));
    tbl.push_back(cmd_row(OP_FREE, 0, 32'hFFFF_F000));
    tbl.push_back(cfg_row(REG_MAX, 32'd4194304));

    foreach (tbl[i]) begin
      if (tbl[i].kind == ROW_CFG) reg_write(tbl[i].reg_idx, tbl[i].reg_val);
      else begin
        issue(tbl[i].op, tbl[i].size, tbl[i].addr, tbl[i].known, tbl[i].res);
        idle_gap(gap_len());
      end
    end

    // Random part: phases with fresh settings, mostly real alloc/free traffic
    for (int ph = 0; ph < N_PHASES; ph++) begin
      reg_write(REG_BASE, ($urandom_range(0, 3) == 0) ? $urandom :
                $urandom_range(1, 32'h7FF0_0000));
      reg_write(REG_MAX, ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4194304) :
                32'd4194304);
      no_gaps = (ph == 2);
      for (int n = 0; n < N_RANDOM / N_PHASES; n++) begin
        pick = $urandom_range(0, 99);
        cmd = OP_ALLOC;
        size = $urandom;
        addr = $urandom;
        if (live_pages.size() > 24 && pick < 60) pick = 50;
        if (pick < 45) size = (pick < 38) ? $urandom_range(1, 16 * PAGE_BYTES) :
                                            $urandom_range(1, 4194304);
        else if (pick < 82 && live_pages.size() != 0) begin
          cmd = OP_FREE;
          addr = sh_base + 32'(live_pages[$urandom_range(0, live_pages.size() - 1)] *
                 PAGE_BYTES) + $urandom_range(0, PAGE_BYTES - 1);
        end else if (pick < 92) begin
          // Stray frees: interior pages, freed heads, past the store
          cmd = OP_FREE;
          addr = sh_base + 32'($urandom_range(0, NUM_PAGES + 8) * PAGE_BYTES);
        end else if (pick < 96) cmd = OP_FREE;
        issue(cmd, size, addr, 0, none);
        idle_gap(gap_len());
      end
    end

    @(negedge clk);
    start = 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
